>>> hdl/ecsp_pkg.sv
package ecsp_pkg;

  // encoder counter wraps at this count
  localparam int COUNT_PERIOD = 2000;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_TARGET_RATE = 3'd3,
    CFG_OUTPUT_MAX  = 3'd4
  } cfg_index_t;

  localparam logic signed [15:0] TARGET_RATE_RST = 16'sd800;
  localparam logic [15:0]        OUTPUT_MAX_RST  = 16'd2000;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic signed [15:0] target_rate;
    logic [15:0]        output_max;
  } cfg_t;

  // saturate a wide signed value to the Q15 range
  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/ecsp_cfg.sv
module ecsp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ecsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ecsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ecsp_pkg::cfg_t                   cfg
);
  import ecsp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p      <= '0;
      cfg.gain_i      <= '0;
      cfg.gain_d      <= '0;
      cfg.target_rate <= TARGET_RATE_RST;
      cfg.output_max  <= OUTPUT_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GAIN_P:      cfg.gain_p      <= cfg_data;
        CFG_GAIN_I:      cfg.gain_i      <= cfg_data;
        CFG_GAIN_D:      cfg.gain_d      <= cfg_data;
        CFG_TARGET_RATE: cfg.target_rate <= cfg_data;
        CFG_OUTPUT_MAX:  cfg.output_max  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/ecsp_speed.sv
module ecsp_speed (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [10:0]        count_value,
  input  logic               count_down,
  output logic signed [15:0] speed
);
  import ecsp_pkg::*;

  logic [10:0]        previous_count;
  logic signed [17:0] cur;
  logic signed [17:0] prev;
  logic signed [17:0] period;
  logic signed [17:0] diff;

  always_comb begin
    cur    = {7'b0, count_value};
    prev   = {7'b0, previous_count};
    period = 18'(COUNT_PERIOD);
    if (!count_down) begin
      diff = (cur < prev) ? (period - prev + cur) : (cur - prev);
    end else begin
      diff = (cur > prev) ? (period - cur + prev) : (prev - cur);
    end
    // doubled, wrapped to 16 bits
    speed = {diff[14:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count <= '0;
    end else if (step) begin
      previous_count <= count_value;
    end
  end

endmodule

>>> hdl/ecsp_pid.sv
module ecsp_pid (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  ecsp_pkg::cfg_t     cfg,
  input  logic signed [15:0] speed,
  output logic [15:0]        pwm_next
);
  import ecsp_pkg::*;

  logic signed [15:0] error_last;
  logic signed [15:0] error_before_last;
  logic signed [15:0] pid_output_last;

  logic signed [15:0] err;
  logic signed [15:0] a0;
  logic signed [15:0] a1;
  logic signed [15:0] a2;
  logic signed [31:0] p0;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [35:0] y_term;
  logic signed [35:0] acc;
  logic signed [35:0] acc_shr;
  logic signed [15:0] y;

  always_comb begin
    err = cfg.target_rate - speed;
    a0  = sat16(36'(cfg.gain_p) + 36'(cfg.gain_i) + 36'(cfg.gain_d));
    a1  = sat16(36'sd0 - (36'(cfg.gain_d) <<< 1) - 36'(cfg.gain_p));
    a2  = cfg.gain_d;
    p0  = 32'(a0) * 32'(err);
    p1  = 32'(a1) * 32'(error_last);
    p2  = 32'(a2) * 32'(error_before_last);
    y_term  = {{5{pid_output_last[15]}}, pid_output_last, 15'b0};
    acc     = 36'(p0) + 36'(p1) + 36'(p2) + y_term;
    acc_shr = acc >>> 15;
    y       = sat16(acc_shr);
    // clamp to the PWM range
    if (y[15]) begin
      pwm_next = '0;
    end else if ($unsigned(y) > cfg.output_max) begin
      pwm_next = cfg.output_max;
    end else begin
      pwm_next = $unsigned(y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_last        <= '0;
      error_before_last <= '0;
      pid_output_last   <= '0;
    end else if (step) begin
      error_before_last <= error_last;
      error_last        <= err;
      pid_output_last   <= y;
    end
  end

endmodule

>>> hdl/encoder_speed_pid_pwm.sv
// Encoder speed PID to PWM. Each item is one control tick carrying the encoder
// counter reading and its direction; the block derives the speed (count
// difference since the last tick, wrapped at the counter period, times two),
// runs a Q15 incremental PID on target_rate minus speed and returns the output
// clamped to 0..output_max as the PWM compare value, plus the low 12 bits of
// the speed. One item per clock is sustained while out_stall is low; a taken
// item sits in the input register, then the result register loads from it once
// the result side is free, limited by the combinational PID pass whose
// state feeds back to the next item. Gains and limits are written through the
// cfg port only while no item is in flight, a rule for the user that the block
// itself does not enforce; writing them leaves the PID history untouched.
module encoder_speed_pid_pwm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ecsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ecsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [10:0]                      count_value,
  input  logic                             count_down,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [15:0]                      pwm_compare,
  output logic [11:0]                      measured_speed
);
  import ecsp_pkg::*;

  cfg_t               cfg;
  logic               s1_valid;
  logic [10:0]        s1_count;
  logic               s1_down;
  logic               advance;
  logic               accept;
  logic signed [15:0] speed;
  logic [15:0]        pwm_next;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  ecsp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ecsp_speed u_speed (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .count_value (s1_count),
    .count_down  (s1_down),
    .speed       (speed)
  );

  ecsp_pid u_pid (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .cfg      (cfg),
    .speed    (speed),
    .pwm_next (pwm_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_count <= count_value;
      s1_down  <= count_down;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pwm_compare    <= pwm_next;
      measured_speed <= speed[11:0];
    end
  end

endmodule

>>> hdl/ecsp_checker.sv
module ecsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] measured_speed
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // input side only backs up when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // a taken item reaches the output once the result register is free
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("item lost in pipeline");

  // speed is a doubled count difference
  a_speed_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !measured_speed[0])
    else $error("odd measured speed");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind encoder_speed_pid_pwm ecsp_checker u_ecsp_checker (.*);

>>> verif/tb_top.sv
module tb_top;
  import ecsp_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_TICKS   = 150;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_INDEX_W'(CFG_OUTPUT_MAX + 1);

  typedef struct packed {
    logic [15:0] pwm;
    logic [11:0] speed;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [10:0] count_value = '0;
  logic count_down = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] pwm_compare;
  logic [11:0] measured_speed;

  // stimulus control
  logic tx_idle_on = 1'b0;
  logic rx_idle_on = 1'b0;
  logic hold_out = 1'b0;
  int stall_left = 0;
  int err_count = 0;

  // controller copy: registers and history
  logic signed [15:0] kp_q, ki_q, kd_q, target_q;
  logic [15:0] out_max_q;
  logic [10:0] last_count;
  logic signed [15:0] err_n1, err_n2, y_n1;

  tick_result_t expected_q[$];

  encoder_speed_pid_pwm i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .count_value(count_value),
    .count_down(count_down),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pwm_compare(pwm_compare),
    .measured_speed(measured_speed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [15:0] q15_clip(input longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  task automatic reset_controller();
    kp_q = '0;
    ki_q = '0;
    kd_q = '0;
    target_q = TARGET_RATE_RST;
    out_max_q = OUTPUT_MAX_RST;
    last_count = '0;
    err_n1 = '0;
    err_n2 = '0;
    y_n1 = '0;
  endtask

  function automatic tick_result_t pid_tick(input logic [10:0] cv, input logic dn);
    int cur, prv, diff;
    logic signed [15:0] speed, err, a0, a1, a2, y;
    longint acc;
    tick_result_t r;
    cur = int'(cv);
    prv = int'(last_count);
    if (!dn) begin
      diff = (cur < prv) ? COUNT_PERIOD - prv + cur : cur - prv;
    end else begin
      diff = (cur > prv) ? COUNT_PERIOD - cur + prv : prv - cur;
    end
    speed = 16'(diff * 2);
    last_count = cv;
    err = 16'(int'(target_q) - int'(speed));
    a0 = q15_clip(longint'(kp_q) + longint'(ki_q) + longint'(kd_q));
    a1 = q15_clip(-(2 * longint'(kd_q) + longint'(kp_q)));
    a2 = kd_q;
    acc = longint'(a0) * longint'(err) + longint'(a1) * longint'(err_n1)
        + longint'(a2) * longint'(err_n2) + (longint'(y_n1) <<< 15);
    y = q15_clip(acc >>> 15);
    err_n2 = err_n1;
    err_n1 = err;
    y_n1 = y;
    if (y < 0) begin
      r.pwm = '0;
    end else if ($unsigned(y) > out_max_q) begin
      r.pwm = out_max_q;
    end else begin
      r.pwm = y;
    end
    r.speed = speed[11:0];
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    err_count++;
  endtask

  // sender: one item per call, valid left high for the next one
  task automatic send_tick(input logic [10:0] cv, input logic dn);
    int gap;
    gap = tx_idle_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    count_value <= cv;
    count_down <= dn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(pid_tick(cv, dn));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while idle; write enable is lowered by the caller's last step
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_GAIN_P:      kp_q = val;
      CFG_GAIN_I:      ki_q = val;
      CFG_GAIN_D:      kd_q = val;
      CFG_TARGET_RATE: target_q = val;
      CFG_OUTPUT_MAX:  out_max_q = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd, input logic [15:0] tgt,
                              input logic [15:0] omax);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_TARGET_RATE, tgt);
    write_reg(CFG_OUTPUT_MAX, omax);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    if (r < 4) return 16'($urandom);
    return 16'(int'($urandom_range(0, 4096)) - 2048);
  endfunction

  // encoder moving mostly upward at a plausible rate, with some noise
  task automatic send_motion_tick();
    logic dn;
    int step;
    if ($urandom_range(0, 99) < 15) begin
      send_tick(11'($urandom), 1'($urandom));
    end else begin
      dn = ($urandom_range(0, 3) == 0);
      step = $urandom_range(0, 400);
      if (!dn) begin
        send_tick(11'((last_count + step) % COUNT_PERIOD), dn);
      end else begin
        send_tick(11'((last_count + COUNT_PERIOD - step) % COUNT_PERIOD), dn);
      end
    end
  endtask

  // result side
  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 32'({pwm_compare, measured_speed}));
      end else begin
        want = expected_q.pop_front();
        if (pwm_compare !== want.pwm) begin
          report_mismatch("pwm_compare", 32'(want.pwm), 32'(pwm_compare));
        end
        if (measured_speed !== want.speed) begin
          report_mismatch("measured_speed", 32'(want.speed), 32'(measured_speed));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_out) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_reset_state();
    send_tick(11'd0, 1'b0);
    send_tick(11'd0, 1'b1);
    drain();
  endtask

  task automatic test_speed_wrap();
    apply_config(16'sd16384, 16'sd8192, 16'sd4096, 16'sd800, 16'd2000);
    send_tick(11'd400, 1'b0);
    send_tick(11'd300, 1'b0);   // up, wraps at the counter period
    send_tick(11'd300, 1'b1);   // no movement
    send_tick(11'd100, 1'b1);
    send_tick(11'd1999, 1'b1);  // down, wraps
    send_tick(11'd2000, 1'b0);
    send_tick(11'd2047, 1'b0);  // beyond the period
    send_tick(11'd0, 1'b0);     // negative speed
    send_tick(11'd2047, 1'b1);
    send_tick(11'd0, 1'b1);     // largest speed
    drain();
  endtask

  task automatic test_gain_extremes();
    apply_config(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send_tick(11'd2047, 1'b1);
    send_tick(11'd0, 1'b0);
    drain();
    apply_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_tick(11'd2047, 1'b0);
    send_tick(11'd1000, 1'b1);
    drain();
    apply_config(16'h7fff, 16'h0000, 16'h8000, 16'h8000, 16'hffff);
    send_tick(11'd0, 1'b1);
    send_tick(11'd1500, 1'b0);
    drain();
    apply_config(16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0001);
    send_tick(11'd1500, 1'b0);
    send_tick(11'd1200, 1'b1);
    drain();
  endtask

  // writes to unused indexes must leave every register alone
  task automatic test_spare_index();
    int i;
    for (i = int'(CFG_SPARE_FIRST); i < (1 << CFG_INDEX_W); i++) begin
      write_reg(CFG_INDEX_W'(i), 16'($urandom));
    end
    cfg_write <= 1'b0;
    @(posedge clk);
    send_tick(11'd1700, 1'b0);
    send_tick(11'd200, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    apply_config(16'sd3000, 16'sd500, 16'sd200, 16'sd600, 16'd3000);
    tx_idle_on = 1'b0;
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
    join_none
    repeat (40) send_motion_tick();
    drain();
  endtask

  task automatic test_random_ticks();
    int p;
    logic [15:0] tgt, omax;
    for (p = 0; p < PHASES; p++) begin
      tx_idle_on = (p % 4 != 1);
      rx_idle_on = (p % 4 != 2);
      tgt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1600));
      case ($urandom_range(0, 4))
        0: omax = 16'h0000;
        1: omax = 16'hffff;
        2: omax = 16'($urandom);
        default: omax = 16'($urandom_range(500, 4000));
      endcase
      apply_config(rand_gain(), rand_gain(), rand_gain(), tgt, omax);
      repeat (PHASE_TICKS) send_motion_tick();
      drain();
    end
  endtask

  initial begin
    reset_controller();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_speed_wrap();
    test_gain_extremes();
    test_spare_index();
    test_backpressure();
    test_random_ticks();
    drain();
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
